[src/utf8s_pkg.sv]
package utf8s_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int MAX_RESULTS = 6;
	localparam int RCNT_W = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	// All bytes that one input byte produces; the first byte sits at index 0.
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [RCNT_W-1:0]           count;
	} run_t;

endpackage

[src/utf8s_front.sv]
module utf8s_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  utf8s_pkg::in_item_t item,
	output utf8s_pkg::run_t     run,
	output logic                q_push,
	input  logic                q_full
);
	import utf8s_pkg::*;

	localparam logic [2:0][7:0] REPL = {8'd189, 8'd191, 8'd239};

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] len;
		if (b[7] == 1'b0)
			len = 3'd1;
		else if (b[7:5] == 3'b110)
			len = 3'd2;
		else if (b[7:4] == 4'b1110)
			len = 3'd3;
		else if (b[7:3] == 5'b11110)
			len = 3'd4;
		else
			len = 3'd0;
		return len;
	endfunction

	function automatic logic seq_ok(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic [2:0] len);
		logic [20:0] cp;
		logic        ok;
		unique case (len)
			3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
			3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
			default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
		endcase
		ok = 1'b1;
		if (cp > 21'h10FFFF)
			ok = 1'b0;
		if (cp >= 21'h00D800 && cp <= 21'h00DFFF)
			ok = 1'b0;
		if (cp < 21'h000080)
			ok = 1'b0;
		if (cp < 21'h000800 && len > 3'd2)
			ok = 1'b0;
		if (cp < 21'h010000 && len > 3'd3)
			ok = 1'b0;
		return ok;
	endfunction

	logic [2:0][7:0] hb_q, hb_d;
	logic [1:0]      held_q, held_d;
	logic [2:0]      exp_q, exp_d;
	logic            skip_q, skip_d;

	logic [7:0] b;
	logic       accept;
	logic       complete;
	logic [2:0] len;
	logic [2:0] lead_len;
	logic [7:0] s1, s2;
	logic       good;
	logic       lead;
	logic       pre;

	assign b        = item.in_byte;
	assign full     = q_full;
	assign accept   = push && !q_full;
	assign len      = {1'b0, held_q} + 3'd1;
	assign complete = (len >= exp_q) || (held_q == 2'd3);
	assign s1       = (held_q == 2'd1) ? b : hb_q[1];
	assign s2       = (held_q == 2'd2) ? b : hb_q[2];
	assign good     = seq_ok(hb_q[0], s1, s2, b, len);
	assign lead_len = seq_len(b);
	assign q_push   = accept && (run.count != '0);

	always_comb begin
		run    = '0;
		hb_d   = hb_q;
		held_d = held_q;
		exp_d  = exp_q;
		skip_d = skip_q;
		lead   = 1'b0;
		pre    = 1'b0;
		if (!(skip_q && is_cont(b))) begin
			skip_d = 1'b0;
			if (held_q != 2'd0) begin
				if (is_cont(b)) begin
					if (complete) begin
						if (good) begin
							run.bytes[3:0] = {b, s2, s1, hb_q[0]};
							run.count      = RCNT_W'(len);
						end else begin
							run.bytes[2:0] = REPL;
							run.count      = RCNT_W'(3);
							skip_d         = 1'b1;
						end
						held_d = 2'd0;
						exp_d  = 3'd0;
					end else begin
						unique case (held_q)
							2'd1:    hb_d[1] = b;
							2'd2:    hb_d[2] = b;
							default: hb_d[0] = b;
						endcase
						held_d = held_q + 2'd1;
					end
				end else begin
					pre    = 1'b1;
					lead   = 1'b1;
					held_d = 2'd0;
					exp_d  = 3'd0;
				end
			end else begin
				lead = 1'b1;
			end
			if (lead) begin
				if (pre)
					run.bytes[2:0] = REPL;
				case (lead_len)
					3'd0: begin
						if (pre) begin
							run.bytes[5:3] = REPL;
							run.count      = RCNT_W'(6);
						end else begin
							run.bytes[2:0] = REPL;
							run.count      = RCNT_W'(3);
						end
					end
					3'd1: begin
						if (pre) begin
							run.bytes[3] = b;
							run.count    = RCNT_W'(4);
						end else begin
							run.bytes[0] = b;
							run.count    = RCNT_W'(1);
						end
					end
					default: begin
						run.count = pre ? RCNT_W'(3) : RCNT_W'(0);
						hb_d[0]   = b;
						held_d    = 2'd1;
						exp_d     = lead_len;
					end
				endcase
			end
		end
		if (item.end_of_text) begin
			held_d = 2'd0;
			exp_d  = 3'd0;
			skip_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 2'd0;
			exp_q  <= 3'd0;
			skip_q <= 1'b0;
		end else if (accept) begin
			held_q <= held_d;
			exp_q  <= exp_d;
			skip_q <= skip_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			hb_q <= hb_d;
	end

	a_held_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != 2'd0 |-> ({1'b0, held_q} < exp_q && exp_q <= 3'd4))
		else $error("held count not below expected length");

	a_skip_idle: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> (held_q == 2'd0 && exp_q == 3'd0))
		else $error("skipping while a sequence is pending");

endmodule

[src/utf8s_queue.sv]
module utf8s_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_push,
	output logic            wr_full,
	input  utf8s_pkg::run_t wr_run,
	output utf8s_pkg::run_t rd_run,
	input  logic            rd_pop,
	output logic            rd_empty
);
	import utf8s_pkg::*;

	run_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr, do_rd;

	assign wr_full  = (cnt_q == QCNT_W'(QDEPTH));
	assign rd_empty = (cnt_q == '0);
	assign do_wr    = wr_push && !wr_full;
	assign do_rd    = rd_pop && !rd_empty;
	assign rd_run   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wp_q] <= wr_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= wp_q + QPTR_W'(1);
			if (do_rd)
				rp_q <= rp_q + QPTR_W'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH) && QPTR_W'(wp_q - rp_q) == cnt_q[QPTR_W-1:0])
		else $error("queue count disagrees with pointers");

endmodule

[src/utf8s_back.sv]
module utf8s_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  utf8s_pkg::run_t      head,
	input  logic                 q_empty,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output utf8s_pkg::out_item_t result
);
	import utf8s_pkg::*;

	out_item_t         out_q;
	logic              valid_q;
	logic [RCNT_W-1:0] idx_q;
	logic              load;
	logic              last;

	assign empty   = !valid_q;
	assign load    = (!valid_q || pop) && !q_empty;
	assign last    = (idx_q == head.count - RCNT_W'(1));
	assign q_pop   = load && last;
	assign result  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last ? '0 : idx_q + RCNT_W'(1);
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte    <= head.bytes[idx_q];
			out_q.last_of_run <= last;
		end
	end

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (idx_q < head.count && head.count <= RCNT_W'(MAX_RESULTS)))
		else $error("byte index outside the queued run");

endmodule

[src/utf8_sanitizer.sv]
// Each run is registered in the run queue, then its bytes in turn in the result register.
// Throughput: one input byte per cycle while the four-entry run queue has room;
// results leave one byte per cycle while pop is high; a run of up to six bytes holds its entry.
// Reset: arst_n clears the pending sequence, the skip flag, the run queue and the result
// valid flag at once; the held sequence bytes themselves are not reset.
module utf8_sanitizer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  utf8s_pkg::in_item_t  item,
	output logic                 empty,
	input  logic                 pop,
	output utf8s_pkg::out_item_t result
);
	import utf8s_pkg::*;

	run_t wr_run, rd_run;
	logic q_push, q_full;
	logic q_pop, q_empty;

	utf8s_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.run   (wr_run),
		.q_push(q_push),
		.q_full(q_full)
	);

	utf8s_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_push (q_push),
		.wr_full (q_full),
		.wr_run  (wr_run),
		.rd_run  (rd_run),
		.rd_pop  (q_pop),
		.rd_empty(q_empty)
	);

	utf8s_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (rd_run),
		.q_empty(q_empty),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
	import utf8s_pkg::*;

	localparam logic [7:0] REPL_0 = 8'hEF;
	localparam logic [7:0] REPL_1 = 8'hBF;
	localparam logic [7:0] REPL_2 = 8'hBD;
	localparam int RANDOM_BYTES = 250;
	localparam int LONG_HOLD = 300;

	typedef struct {
		in_item_t it;
		bit       drain;
	} raw_byte_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  item = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t result;

	raw_byte_t raw_bytes[$];
	out_item_t expected_out[$];
	int        failures = 0;

	// Sanitiser state as the predictor sees it.
	logic [7:0] held_bytes [0:2];
	int         held_cnt = 0;
	int         seq_len = 0;
	bit         skipping = 1'b0;

	utf8_sanitizer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	task automatic sanitise_byte(input in_item_t it);
		logic [7:0] b;
		logic [7:0] run[$];
		logic [7:0] seq [0:3];
		logic [31:0] cp;
		int len;
		bit lead;
		bit ok;
		out_item_t r;
		b = it.in_byte;
		lead = 1'b1;
		if (skipping && is_cont(b)) begin
			lead = 1'b0;
		end else begin
			skipping = 1'b0;
			if (held_cnt > 0) begin
				if (is_cont(b)) begin
					lead = 1'b0;
					if (held_cnt + 1 >= seq_len || held_cnt >= 3) begin
						len = held_cnt + 1;
						for (int i = 0; i < held_cnt; i++)
							seq[i] = held_bytes[i];
						seq[len-1] = b;
						if (len == 2) begin
							cp = {21'd0, seq[0][4:0], seq[1][5:0]};
						end else if (len == 3) begin
							cp = {16'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
						end else begin
							cp = {11'd0, seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
						end
						ok = !(cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF) ||
							cp < 32'h80 || (cp < 32'h800 && len > 2) ||
							(cp < 32'h10000 && len > 3));
						if (ok) begin
							for (int i = 0; i < len; i++)
								run.push_back(seq[i]);
						end else begin
							run.push_back(REPL_0);
							run.push_back(REPL_1);
							run.push_back(REPL_2);
							skipping = 1'b1;
						end
						held_cnt = 0;
						seq_len = 0;
					end else begin
						held_bytes[held_cnt] = b;
						held_cnt++;
					end
				end else begin
					run.push_back(REPL_0);
					run.push_back(REPL_1);
					run.push_back(REPL_2);
					held_cnt = 0;
					seq_len = 0;
				end
			end
			if (lead) begin
				if (b[7] == 1'b0) begin
					run.push_back(b);
				end else if (b[7:5] == 3'b110 || b[7:4] == 4'hE || b[7:3] == 5'h1E) begin
					held_bytes[0] = b;
					held_cnt = 1;
					seq_len = (b[7:5] == 3'b110) ? 2 : (b[7:4] == 4'hE) ? 3 : 4;
				end else begin
					run.push_back(REPL_0);
					run.push_back(REPL_1);
					run.push_back(REPL_2);
				end
			end
		end
		if (it.end_of_text) begin
			held_cnt = 0;
			seq_len = 0;
			skipping = 1'b0;
		end
		for (int i = 0; i < run.size(); i++) begin
			r.out_byte = run[i];
			r.last_of_run = (i == run.size() - 1);
			expected_out.push_back(r);
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input bit eot, input bit drain = 1'b0);
		raw_byte_t rb;
		rb.it.in_byte = b;
		rb.it.end_of_text = eot;
		rb.drain = drain;
		raw_bytes.push_back(rb);
	endtask

	task automatic queue_seq(input logic [7:0] lead_byte, input int trails);
		queue_byte(lead_byte, $urandom_range(0, 19) == 0);
		for (int i = 0; i < trails; i++)
			queue_byte(8'($urandom_range(8'h80, 8'hBF)), $urandom_range(0, 19) == 0);
	endtask

	task automatic queue_random(input int count);
		int target;
		int kind;
		target = raw_bytes.size() + count;
		while (raw_bytes.size() < target) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1: queue_seq(8'($urandom_range(0, 8'h7F)), 0);
				2: queue_seq(8'($urandom_range(8'hC2, 8'hDF)), 1);
				3: queue_seq(8'($urandom_range(8'hE0, 8'hEF)), 2);
				4: queue_seq(8'($urandom_range(8'hF0, 8'hF4)), 3);
				5: queue_byte(8'($urandom), 1'($urandom_range(0, 1)));
				6: begin
					if ($urandom_range(0, 1))
						queue_seq(8'($urandom_range(8'hE0, 8'hEF)), $urandom_range(0, 1));
					else
						queue_seq(8'($urandom_range(8'hF0, 8'hF4)), $urandom_range(0, 2));
				end
				7: begin
					if ($urandom_range(0, 1))
						queue_seq(8'($urandom_range(8'hC0, 8'hC1)), 1 + $urandom_range(0, 2));
					else
						queue_seq(8'($urandom_range(8'hF5, 8'hF7)), 3 + $urandom_range(0, 2));
				end
				8: for (int i = $urandom_range(1, 3); i > 0; i--)
					queue_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
				default: queue_byte(8'($urandom_range(8'hF8, 8'hFF)), 1'b0);
			endcase
		end
	endtask

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 8;
	int gap_left = 0;
	raw_byte_t next_raw;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
		end else begin
			if (push && !full)
				sanitise_byte(item);
			if (!(push && full)) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (raw_bytes.size() != 0 &&
					!(raw_bytes[0].drain && expected_out.size() != 0)) begin
					next_raw = raw_bytes.pop_front();
					push <= 1'b1;
					item <= next_raw.it;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall rate changes from phase to phase, with one long hold-off.
	int pop_pct = 100;
	int phase_left = 0;
	int hold_left = 0;
	bit held_off = 1'b0;
	int checked = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				checked++;
				if (expected_out.size() == 0) begin
					$error("unexpected result: out_byte %h last_of_run %b",
						result.out_byte, result.last_of_run);
					failures++;
				end else begin
					out_item_t exp_r;
					exp_r = expected_out.pop_front();
					if (result.out_byte !== exp_r.out_byte) begin
						$error("out_byte: expected %h, actual %h", exp_r.out_byte, result.out_byte);
						failures++;
					end
					if (result.last_of_run !== exp_r.last_of_run) begin
						$error("last_of_run: expected %b, actual %b",
							exp_r.last_of_run, result.last_of_run);
						failures++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!held_off && checked >= 60) begin
				held_off = 1'b1;
				hold_left = LONG_HOLD;
				pop <= 1'b0;
			end else begin
				if (phase_left <= 0) begin
					case ($urandom_range(0, 3))
						0: pop_pct = 100;
						1: pop_pct = 75;
						2: pop_pct = 40;
						default: pop_pct = 15;
					endcase
					phase_left = $urandom_range(20, 80);
				end
				phase_left--;
				pop <= ($urandom_range(1, 100) <= pop_pct);
			end
		end
	end

	initial begin
		// Directed bytes: invalid leads, valid runs of each length, several kinds of bad sequence.
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hF8, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'hC2, 1'b0);
		queue_byte(8'hA9, 1'b0);
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h82, 1'b0);
		queue_byte(8'hAC, 1'b0);
		queue_byte(8'hF4, 1'b0);
		queue_byte(8'h8F, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hC0, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hED, 1'b0);
		queue_byte(8'hA0, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h41, 1'b0);
		queue_byte(8'hF4, 1'b0);
		queue_byte(8'h90, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h82, 1'b1);
		queue_random(RANDOM_BYTES / 2);
		queue_byte(8'($urandom_range(0, 8'h7F)), 1'b0, 1'b1);
		queue_random(RANDOM_BYTES / 2);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (raw_bytes.size() != 0 || push)
			@(posedge clk);
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0 && expected_out.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
